### sv/cdrq_pkg.sv
// Package for the C-LOOK disk request queue.
// Holds sizes, status codes and the beat structs shared by all modules.
// No dependencies.
package cdrq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int SECTOR_BITS = 48;
    localparam int TAG_BITS    = 8;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Command codes
    localparam logic CMD_ADD      = 1'b0;
    localparam logic CMD_DISPATCH = 1'b1;

    // Status codes
    localparam logic [1:0] ST_ADDED      = 2'd0;
    localparam logic [1:0] ST_DISPATCHED = 2'd1;
    localparam logic [1:0] ST_EMPTY      = 2'd2;
    localparam logic [1:0] ST_FULL       = 2'd3;

    // Input beat
    typedef struct packed {
        logic                   cmd;
        logic [SECTOR_BITS-1:0] sector;
        logic [TAG_BITS-1:0]    tag;
    } cdrq_req_t;

    // Result beat
    typedef struct packed {
        logic [1:0]             status;
        logic [SECTOR_BITS-1:0] out_sector;
        logic [TAG_BITS-1:0]    out_tag;
    } cdrq_rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic commit;
    } cdrq_ctl_t;

endpackage

### sv/cdrq_ctrl.sv
// Controller for the C-LOOK disk request queue.
// Sequences capture (compare) and commit (shift) of one command.
// Depends on cdrq_pkg.
module cdrq_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output cdrq_pkg::cdrq_ctl_t ctl
);

    typedef enum logic {
        S_IDLE,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;
    logic   capture;

    // Accept a beat only when not committing the previous one
    assign capture = start && !busy_reg;

    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (capture)
                begin
                    state_next = S_COMMIT;
                    busy_next  = 1'b1;
                end
            end
            S_COMMIT:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
            default:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy        = busy_reg;
    assign ctl.capture = capture;
    assign ctl.commit  = (state_reg == S_COMMIT);

`ifndef SYNTH
    a_busy_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (state_reg == S_COMMIT))
        else $error("busy out of step with state");
    a_capture_then_commit: assert property (@(posedge clk) disable iff (!rst_n)
        capture |=> ctl.commit && !capture)
        else $error("capture not followed by commit");
`endif

endmodule

### sv/cdrq_datapath.sv
// Datapath for the C-LOOK disk request queue: shift-register sorted entries,
// per-cell insertion compares, head position and result register.
// Depends on cdrq_pkg.
module cdrq_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  cdrq_pkg::cdrq_ctl_t ctl,
    input  cdrq_pkg::cdrq_req_t req,
    output cdrq_pkg::cdrq_rsp_t result,
    output logic                done
);

    localparam int D  = cdrq_pkg::QUEUE_DEPTH;
    localparam int SB = cdrq_pkg::SECTOR_BITS;
    localparam int TB = cdrq_pkg::TAG_BITS;
    localparam int CW = cdrq_pkg::CNT_W;

    logic [SB-1:0]       sector_reg [D];
    logic [TB-1:0]       tag_reg    [D];
    logic [CW-1:0]       count_reg;
    logic [SB-1:0]       head_reg;
    logic                cmd_reg;
    logic [SB-1:0]       new_sector_reg;
    logic [TB-1:0]       new_tag_reg;
    logic [D-1:0]        hit_reg;
    logic [D-1:0]        hit_next;
    logic [D-1:0]        ins_mask;
    logic                below;
    logic                is_full;
    logic                is_empty;
    cdrq_pkg::cdrq_rsp_t result_reg;
    logic                done_reg;

    assign is_full  = (count_reg == CW'(D));
    assign is_empty = (count_reg == '0);

    // Per-cell insertion match against the incoming sector
    assign below = (req.sector < head_reg);
    always_comb
    begin
        for (int i = 0; i < D; i++)
        begin
            if (CW'(i) >= count_reg)
                hit_next[i] = 1'b1;
            else if (below)
                hit_next[i] = (sector_reg[i] < head_reg) && (req.sector < sector_reg[i]);
            else
                hit_next[i] = (sector_reg[i] < head_reg) || (req.sector < sector_reg[i]);
        end
    end

    // Cells at or after the first hit take part in the insert
    assign ins_mask = ~((hit_reg & (~hit_reg + D'(1))) - D'(1));

    // Capture the beat and its match vector
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg        <= req.cmd;
            new_sector_reg <= req.sector;
            new_tag_reg    <= req.tag;
            hit_reg        <= hit_next;
        end
    end

    // Entry cells: insert shifts toward the tail, dispatch toward the front
    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            if (cmd_reg == cdrq_pkg::CMD_ADD)
            begin
                if (!is_full)
                begin
                    for (int i = 0; i < D; i++)
                    begin
                        if (ins_mask[i])
                        begin
                            if (i > 0 && ins_mask[(i > 0) ? i - 1 : 0])
                            begin
                                sector_reg[i] <= sector_reg[(i > 0) ? i - 1 : 0];
                                tag_reg[i]    <= tag_reg[(i > 0) ? i - 1 : 0];
                            end
                            else
                            begin
                                sector_reg[i] <= new_sector_reg;
                                tag_reg[i]    <= new_tag_reg;
                            end
                        end
                    end
                end
            end
            else if (!is_empty)
            begin
                for (int i = 0; i < D - 1; i++)
                begin
                    sector_reg[i] <= sector_reg[i + 1];
                    tag_reg[i]    <= tag_reg[i + 1];
                end
            end
        end
    end

    // Count and head position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            head_reg  <= SB'(1);
        end
        else if (ctl.commit)
        begin
            if (cmd_reg == cdrq_pkg::CMD_ADD)
            begin
                if (!is_full)
                    count_reg <= count_reg + CW'(1);
            end
            else if (!is_empty)
            begin
                count_reg <= count_reg - CW'(1);
                head_reg  <= sector_reg[0];
            end
        end
    end

    // Result beat, registered on commit
    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            result_reg.out_sector <= '0;
            result_reg.out_tag    <= '0;
            if (cmd_reg == cdrq_pkg::CMD_ADD)
                result_reg.status <= is_full ? cdrq_pkg::ST_FULL : cdrq_pkg::ST_ADDED;
            else if (is_empty)
                result_reg.status <= cdrq_pkg::ST_EMPTY;
            else
            begin
                result_reg.status     <= cdrq_pkg::ST_DISPATCHED;
                result_reg.out_sector <= sector_reg[0];
                result_reg.out_tag    <= tag_reg[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctl.commit;
    end

    assign result = result_reg;
    assign done   = done_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(D))
        else $error("entry count above depth");
    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit && cmd_reg == cdrq_pkg::CMD_ADD && !is_full
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("add did not grow the queue");
    a_head_moves: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit && cmd_reg == cdrq_pkg::CMD_DISPATCH && !is_empty
        |=> head_reg == $past(sector_reg[0]) && result_reg.out_sector == head_reg)
        else $error("head not moved to dispatched sector");
`endif

endmodule

### sv/clook_disk_request_queue.sv
// C-LOOK disk request queue, top level: controller plus datapath.
// The result strobe (done) is registered from the commit state that follows the accepting edge.
// A new command is not taken while busy; busy covers the commit cycle, where
// the entry cells shift by one place. The receiver cannot stall results.
// Reset: asynchronous, active low; queue empty, head position 1.
module clook_disk_request_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  cdrq_pkg::cdrq_req_t req,
    output logic                done,
    output cdrq_pkg::cdrq_rsp_t result
);

    cdrq_pkg::cdrq_ctl_t ctl;

    cdrq_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctl   (ctl)
    );

    cdrq_datapath u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .req    (req),
        .result (result),
        .done   (done)
    );

endmodule

### tb/tb_clook_disk_request_queue.sv
// Self-checking testbench for the C-LOOK disk request queue.
// Drives add and dispatch beats with random gaps and checks every result beat.
// The expected values come from an in-bench scheduler model. Depends on cdrq_pkg.
`timescale 1ns / 100ps

module tb_clook_disk_request_queue;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 8;
    localparam int RANDOM_ITEMS = 1700;
    localparam int QUEUE_DEPTH  = cdrq_pkg::QUEUE_DEPTH;
    localparam int SECTOR_BITS  = cdrq_pkg::SECTOR_BITS;
    localparam int TAG_BITS     = cdrq_pkg::TAG_BITS;

    // One queued command together with its lead-in gap
    typedef struct {
        cdrq_pkg::cdrq_req_t req;
        int                  gap;
        bit                  drain;
    } cmd_slot_t;

    logic                clk   = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    cdrq_pkg::cdrq_req_t req   = '0;
    logic                busy;
    logic                done;
    cdrq_pkg::cdrq_rsp_t result;

    cmd_slot_t           cmd_backlog[$];
    cdrq_pkg::cdrq_rsp_t awaited_rsp[$];

    int accept_count = 0;
    int taken_count  = 0;
    int gap_left     = 0;
    bit gap_loaded   = 1'b0;
    int fail_count   = 0;
    int cycle_count  = 0;

    // Scheduler model state
    logic [SECTOR_BITS-1:0] sched_sector[QUEUE_DEPTH];
    logic [TAG_BITS-1:0]    sched_tag[QUEUE_DEPTH];
    int                     sched_count = 0;
    logic [SECTOR_BITS-1:0] head_sector = SECTOR_BITS'(1);

    clook_disk_request_queue DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Apply one command to the model; returns the response it should give
    function automatic cdrq_pkg::cdrq_rsp_t serve_request(cdrq_pkg::cdrq_req_t r);
        cdrq_pkg::cdrq_rsp_t o;
        int                  pos;
        int                  i;
        bit                  below;
        o = '0;
        if (r.cmd == cdrq_pkg::CMD_ADD)
        begin
            if (sched_count >= QUEUE_DEPTH)
            begin
                o.status = cdrq_pkg::ST_FULL;
            end
            else
            begin
                below = r.sector < head_sector;
                pos = sched_count;
                for (i = sched_count - 1; i >= 0; i--)
                begin
                    if (below ? (sched_sector[i] < head_sector && r.sector < sched_sector[i])
                              : (sched_sector[i] < head_sector || r.sector < sched_sector[i]))
                        pos = i;
                end
                for (i = sched_count; i > pos; i--)
                begin
                    sched_sector[i] = sched_sector[i-1];
                    sched_tag[i]    = sched_tag[i-1];
                end
                sched_sector[pos] = r.sector;
                sched_tag[pos]    = r.tag;
                sched_count++;
                o.status = cdrq_pkg::ST_ADDED;
            end
        end
        else if (sched_count == 0)
        begin
            o.status = cdrq_pkg::ST_EMPTY;
        end
        else
        begin
            o.status     = cdrq_pkg::ST_DISPATCHED;
            o.out_sector = sched_sector[0];
            o.out_tag    = sched_tag[0];
            head_sector  = sched_sector[0];
            for (i = 1; i < sched_count; i++)
            begin
                sched_sector[i-1] = sched_sector[i];
                sched_tag[i-1]    = sched_tag[i];
            end
            sched_count--;
        end
        return o;
    endfunction

    // Sectors: clustered small values for ties, full-width values, and the extremes
    function automatic logic [SECTOR_BITS-1:0] pick_sector();
        logic [63:0] w;
        int          sel;
        sel = $urandom_range(0, 9);
        w = {$urandom, $urandom};
        if (sel <= 3)
            return SECTOR_BITS'($urandom_range(0, 40));
        else if (sel <= 6)
            return w[SECTOR_BITS-1:0];
        else if (sel == 7)
            return '0;
        else if (sel == 8)
            return '1;
        return SECTOR_BITS'($urandom_range(1, 2));
    endfunction

    task automatic queue_cmd(logic cmd, logic [SECTOR_BITS-1:0] s, logic [TAG_BITS-1:0] t,
                             int gap, bit drain);
        cmd_slot_t c;
        c.req.cmd    = cmd;
        c.req.sector = s;
        c.req.tag    = t;
        c.gap        = gap;
        c.drain      = drain;
        cmd_backlog.push_back(c);
    endtask

    // Driver: presents one beat at a time, changes on the falling edge
    always @(negedge clk)
    begin : drive
        logic                nxt_start;
        cdrq_pkg::cdrq_req_t nxt_req;
        nxt_start = start;
        nxt_req   = req;
        if (rst_n)
        begin
            if (start && accept_count != taken_count)
            begin
                taken_count++;
                void'(cmd_backlog.pop_front());
                gap_loaded = 1'b0;
                nxt_start  = 1'b0;
            end
            if (!nxt_start && cmd_backlog.size() > 0)
            begin
                if (!gap_loaded)
                begin
                    gap_left   = cmd_backlog[0].gap;
                    gap_loaded = 1'b1;
                end
                if (gap_left > 0)
                    gap_left--;
                else if (!cmd_backlog[0].drain || awaited_rsp.size() == 0)
                begin
                    nxt_start = 1'b1;
                    nxt_req   = cmd_backlog[0].req;
                end
            end
        end
        start <= nxt_start;
        req   <= nxt_req;
    end

    // Monitor: checks result beats, predicts on each accepted beat
    always @(posedge clk)
    begin : watch
        cdrq_pkg::cdrq_rsp_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result beat, expected none, actual %h", $time,
                             result);
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (result.status !== want.status)
                    begin
                        fail_count++;
                        $display("%0t: status expected %0d actual %0d", $time, want.status,
                                 result.status);
                    end
                    if (result.out_sector !== want.out_sector)
                    begin
                        fail_count++;
                        $display("%0t: out_sector expected %h actual %h", $time,
                                 want.out_sector, result.out_sector);
                    end
                    if (result.out_tag !== want.out_tag)
                    begin
                        fail_count++;
                        $display("%0t: out_tag expected %h actual %h", $time, want.out_tag,
                                 result.out_tag);
                    end
                end
            end
            if (start && !busy)
            begin
                awaited_rsp.push_back(serve_request(req));
                accept_count++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin : main
        int made;
        int kind;
        int span;
        int gap_mode;
        int add_pct;
        int gap;
        int k;

        // Directed: empty dispatch, extremes, ties at the head, wrap below the head
        queue_cmd(cdrq_pkg::CMD_DISPATCH, '1, '1, 0, 1'b0);
        queue_cmd(cdrq_pkg::CMD_ADD, '0, 8'h00, 0, 1'b0);
        queue_cmd(cdrq_pkg::CMD_ADD, SECTOR_BITS'(1), 8'hFF, 0, 1'b0);
        queue_cmd(cdrq_pkg::CMD_ADD, '1, 8'hA5, 1, 1'b0);
        queue_cmd(cdrq_pkg::CMD_ADD, SECTOR_BITS'(5), 8'h5A, 0, 1'b0);
        queue_cmd(cdrq_pkg::CMD_ADD, SECTOR_BITS'(1), 8'h11, 2, 1'b0);
        queue_cmd(cdrq_pkg::CMD_DISPATCH, '0, '0, 0, 1'b0);
        queue_cmd(cdrq_pkg::CMD_DISPATCH, '1, '1, 0, 1'b0);
        queue_cmd(cdrq_pkg::CMD_DISPATCH, '0, '0, 3, 1'b0);
        queue_cmd(cdrq_pkg::CMD_ADD, '0, 8'h22, 0, 1'b1);
        queue_cmd(cdrq_pkg::CMD_ADD, SECTOR_BITS'(3), 8'h33, 0, 1'b0);
        queue_cmd(cdrq_pkg::CMD_ADD, SECTOR_BITS'(7), 8'h44, 0, 1'b0);
        queue_cmd(cdrq_pkg::CMD_ADD, '1, 8'h55, 0, 1'b0);
        for (k = 0; k < 8; k++)
            queue_cmd(cdrq_pkg::CMD_DISPATCH, SECTOR_BITS'(k), TAG_BITS'(k), k % 3, 1'b0);
        queue_cmd(cdrq_pkg::CMD_DISPATCH, '0, '0, 0, 1'b0);

        // Random phases: fill toward full, drain toward empty, or mixed traffic
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            kind     = $urandom_range(0, 2);
            span     = $urandom_range(20, 60);
            gap_mode = $urandom_range(0, 2);
            add_pct  = (kind == 0) ? 85 : (kind == 1) ? 15 : 50;
            for (k = 0; k < span; k++)
            begin
                gap = (gap_mode == 0) ? 0 :
                      (gap_mode == 1) ? $urandom_range(0, 19) : $urandom_range(0, 3);
                queue_cmd(($urandom_range(1, 100) <= add_pct) ? cdrq_pkg::CMD_ADD
                                                              : cdrq_pkg::CMD_DISPATCH,
                          pick_sector(), TAG_BITS'($urandom), gap,
                          (k == 0) && ($urandom_range(0, 3) == 0));
                made++;
            end
        end

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || start)
            @(posedge clk);
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
